### sv/pcw_pkg.sv
package pcw_pkg;

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 7;
   localparam int VAL_W  = 16;
   localparam int SLOT_W = 4;
   localparam int PAGE_W = 7;

   // smallest link that names a data page
   localparam logic [VAL_W-1:0] MIN_LINK = 16'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_CMP    = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CMP,
      ST_WALK,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic push;
      logic commit_ok;
      logic commit_fail;
   } q_ctrl_type;

endpackage

### sv/page_chain_walker.sv
// channel  | direction | handshake           | payload
// req_     | in        | req_valid/req_ready | func, entry_index, entry_value,
//          |           |                     | head_page, book_slot
// rsp_     | out       | rsp_valid/rsp_ready | page, ok, last
//
// a load writes the table directly, a mirror compare makes one link table read
// lookup follows one link per cycle through the single read port of the link table,
// then commits the run into the output line
// reset and a clear request both sweep every table entry, with req_ready low
// results are buffered; loads and compares are taken while responses drain, and a
// finished lookup waits in the commit state until the previous run is fully delivered
module page_chain_walker #(
   parameter int TABLE_ENTRIES    = 128,
   parameter int PAGES_PER_RECORD = 4,
   parameter int RECORDS_PER_FILE = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [pcw_pkg::FUNC_W-1:0] req_func,
   input  logic [pcw_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [pcw_pkg::VAL_W-1:0]  req_entry_value,
   input  logic [pcw_pkg::IDX_W-1:0]  req_head_page,
   input  logic [pcw_pkg::SLOT_W-1:0] req_book_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [pcw_pkg::PAGE_W-1:0] rsp_page,
   output logic                       rsp_ok,
   output logic                       rsp_last
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(RECORDS_PER_FILE * PAGES_PER_RECORD + 1);

   pcw_pkg::state_type state_ff, state_in;
   pcw_pkg::func_type  func;
   pcw_pkg::q_ctrl_type q_ctrl;

   logic [AW-1:0]             clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]             walk_cnt_ff, walk_cnt_in;
   logic [CW-1:0]             first_ff, first_in;   // first link count inside the record
   logic [CW-1:0]             last_ff, last_in;     // link count of the trailing check
   logic                      walk_ok_ff, walk_ok_in;
   logic                      mirror_bad_ff, mirror_bad_in;
   logic [pcw_pkg::VAL_W-1:0] cmp_value_ff, cmp_value_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [pcw_pkg::VAL_W-1:0] wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [pcw_pkg::VAL_W-1:0] rd_data;
   logic                      q_idle;

   logic req_fire;
   logic idx_in_range;
   logic lookup_good;
   logic link_good;
   logic in_window;
   logic walk_end;

   assign req_ready = (state_ff == pcw_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign func      = pcw_pkg::func_type'(req_func);

   assign idx_in_range = 32'(req_entry_index) < 32'(TABLE_ENTRIES);

   // lookup fails at once on a mismatched mirror or an out-of-range start or slot
   assign lookup_good = !mirror_bad_ff
                        && (32'(req_head_page) < 32'(TABLE_ENTRIES))
                        && (32'(req_book_slot) < 32'(RECORDS_PER_FILE));

   // a link must name a data page inside the table
   assign link_good = (rd_data >= pcw_pkg::MIN_LINK)
                      && (32'(rd_data) < 32'(TABLE_ENTRIES));

   assign in_window = (walk_cnt_ff >= first_ff) && (walk_cnt_ff < last_ff);
   assign walk_end  = (walk_cnt_ff == last_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcw_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == AW'(TABLE_ENTRIES - 1)) begin
               state_in = pcw_pkg::ST_IDLE;
            end
         end
         pcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  pcw_pkg::FUNC_CMP: begin
                     if (idx_in_range) begin
                        state_in = pcw_pkg::ST_CMP;
                     end
                  end
                  pcw_pkg::FUNC_LOOKUP: begin
                     state_in = lookup_good ? pcw_pkg::ST_WALK : pcw_pkg::ST_COMMIT;
                  end
                  pcw_pkg::FUNC_CLEAR: begin
                     state_in = pcw_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = pcw_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pcw_pkg::ST_CMP: begin
            state_in = pcw_pkg::ST_IDLE;
         end
         pcw_pkg::ST_WALK: begin
            if (!link_good || walk_end) begin
               state_in = pcw_pkg::ST_COMMIT;
            end
         end
         pcw_pkg::ST_COMMIT: begin
            if (q_idle) begin
               state_in = pcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcw_pkg::ST_IDLE;
         end
      endcase
   end

   // table access, counters and flags
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      walk_cnt_in   = walk_cnt_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      walk_ok_in    = walk_ok_ff;
      mirror_bad_in = mirror_bad_ff;
      cmp_value_in  = cmp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_cnt_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = AW'(rd_data);
      q_ctrl        = '0;
      case (state_ff)
         pcw_pkg::ST_CLEAR: begin
            // sweep one entry per cycle
            wr_en         = 1'b1;
            clr_cnt_in    = clr_cnt_ff + AW'(1);
            mirror_bad_in = 1'b0;
         end
         pcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  pcw_pkg::FUNC_LOAD: begin
                     wr_en   = idx_in_range;
                     wr_addr = AW'(req_entry_index);
                     wr_data = req_entry_value;
                  end
                  pcw_pkg::FUNC_CMP: begin
                     rd_en        = idx_in_range;
                     rd_addr      = AW'(req_entry_index);
                     cmp_value_in = req_entry_value;
                  end
                  pcw_pkg::FUNC_LOOKUP: begin
                     rd_en       = lookup_good;
                     rd_addr     = AW'(req_head_page);
                     walk_cnt_in = '0;
                     first_in    = CW'(req_book_slot) * CW'(PAGES_PER_RECORD);
                     last_in     = CW'(req_book_slot) * CW'(PAGES_PER_RECORD)
                                   + CW'(PAGES_PER_RECORD);
                     walk_ok_in  = 1'b0;
                  end
                  pcw_pkg::FUNC_CLEAR: begin
                     clr_cnt_in    = '0;
                     mirror_bad_in = 1'b0;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end
         end
         pcw_pkg::ST_CMP: begin
            // sticky mismatch flag
            if (rd_data != cmp_value_ff) begin
               mirror_bad_in = 1'b1;
            end
         end
         pcw_pkg::ST_WALK: begin
            // rd_data holds the link read for walk_cnt_ff
            if (link_good) begin
               if (walk_end) begin
                  walk_ok_in = 1'b1;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = AW'(rd_data);
                  walk_cnt_in = walk_cnt_ff + CW'(1);
                  q_ctrl.push = in_window;
               end
            end else begin
               walk_ok_in = 1'b0;
            end
         end
         pcw_pkg::ST_COMMIT: begin
            // hand the run to the output line once the previous one is gone
            if (q_idle) begin
               q_ctrl.commit_ok   = walk_ok_ff;
               q_ctrl.commit_fail = !walk_ok_ff;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcw_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         mirror_bad_ff <= 1'b0;
         walk_cnt_ff   <= '0;
         walk_ok_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         mirror_bad_ff <= mirror_bad_in;
         walk_cnt_ff   <= walk_cnt_in;
         walk_ok_ff    <= walk_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      last_ff      <= last_in;
      cmp_value_ff <= cmp_value_in;
   end

   pcw_link_ram #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcw_page_queue #(
      .PAGES (PAGES_PER_RECORD)
   ) u_page_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_page (rd_data[pcw_pkg::PAGE_W-1:0]),
      .idle      (q_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_page  (rsp_page),
      .rsp_ok    (rsp_ok),
      .rsp_last  (rsp_last)
   );

endmodule

### sv/pcw_link_ram.sv
module pcw_link_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [pcw_pkg::VAL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [pcw_pkg::VAL_W-1:0] rd_data
);

   logic [pcw_pkg::VAL_W-1:0] mem_ff [DEPTH];
   logic [pcw_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pcw_page_queue.sv
module pcw_page_queue #(
   parameter int PAGES = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pcw_pkg::q_ctrl_type        ctrl,
   input  logic [pcw_pkg::PAGE_W-1:0] push_page,
   output logic                       idle,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [pcw_pkg::PAGE_W-1:0] rsp_page,
   output logic                       rsp_ok,
   output logic                       rsp_last
);

   localparam int RW = $clog2(PAGES + 1);

   logic [pcw_pkg::PAGE_W-1:0] stage_ff [PAGES];
   logic [pcw_pkg::PAGE_W-1:0] stage_in [PAGES];
   logic [pcw_pkg::PAGE_W-1:0] out_ff   [PAGES];
   logic [pcw_pkg::PAGE_W-1:0] out_in   [PAGES];
   logic [RW-1:0]              remain_ff;
   logic [RW-1:0]              remain_in;
   logic                       ok_ff;
   logic                       ok_in;

   // staging line collects pages during a walk
   always_comb begin
      stage_in = stage_ff;
      if (ctrl.push) begin
         for (int i = 0; i < PAGES - 1; i++) begin
            stage_in[i] = stage_ff[i + 1];
         end
         stage_in[PAGES-1] = push_page;
      end
   end

   // output line drains one page per response
   always_comb begin
      out_in    = out_ff;
      remain_in = remain_ff;
      ok_in     = ok_ff;
      if (ctrl.commit_ok) begin
         out_in    = stage_ff;
         remain_in = RW'(PAGES);
         ok_in     = 1'b1;
      end else if (ctrl.commit_fail) begin
         out_in[0] = '0;
         remain_in = RW'(1);
         ok_in     = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < PAGES - 1; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         remain_in = remain_ff - RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
      ok_ff    <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   assign idle      = (remain_ff == '0);
   assign rsp_valid = !idle;
   assign rsp_page  = out_ff[0];
   assign rsp_ok    = ok_ff;
   assign rsp_last  = (remain_ff == RW'(1));

endmodule
